>>> sv/clt_pkg.sv
// Package for the compacting list table: sizes, operation and status codes,
// and the per-cell control struct. Used by every module of the block.
`timescale 1ns / 1ps

package clt_pkg;

    localparam int DEPTH       = 64;
    localparam int ELEM_BITS   = 32;
    localparam int IDX_BITS    = 6;
    localparam int CNT_BITS    = 7;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = DEPTH / GROUP_SIZE;
    localparam int GSEL_BITS   = 3;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_GROUP
    } state_t;

    typedef struct packed {
        logic load;   // store the incoming value in this cell
        logic shift;  // take the word of the right-hand neighbor
        logic probe;  // capture a compare result for a find
        logic live;   // this cell holds a valid entry
    } cell_ctrl_t;

endpackage

>>> sv/compacting_list_table.sv
// Top level of the compacting list table: control, entry count, the cell chain
// and the find encoder. Depends on clt_pkg, clt_cell and clt_find_tree.
`timescale 1ns / 1ps

// The table keeps an ordered list of up to 64 words of 32 bits in a chain of
// cells, one cell per entry. A command is transferred at a rising edge where
// start is high and busy is low. Append, remove and the unused operation code
// complete at that edge; their result is shown for one cycle, marked by done,
// in the very next cycle, and busy stays low, so one of these commands can be
// issued every cycle. A remove moves every later entry one cell down in that
// same edge, each cell taking the word of its right-hand neighbor. In a find,
// the cells register their compare flags at the transfer edge, then the first
// stage of a two-level first-match encoder registers, and then the result and
// done are registered; busy is high in between. Results cannot be held off:
// done is a one-cycle strobe and the receiver must take status, found_position
// and count in that cycle. count always gives the number of stored entries
// after the reported command. There is no clearing pass after reset: the list
// is empty and can be used at once.
module compacting_list_table
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] value,
    input  logic [5:0]  position,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  found_position,
    output logic [6:0]  count
);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic                  done_reg;
    logic                  done_next;
    status_t               status_reg;
    status_t               status_next;
    logic [IDX_BITS-1:0]   found_reg;
    logic [IDX_BITS-1:0]   found_next;

    logic                  accept;
    op_t                   op;
    logic [ELEM_BITS-1:0]  elem;
    logic                  append_ok;
    logic                  remove_ok;
    logic                  do_append;
    logic                  do_remove;
    logic                  do_find;

    cell_ctrl_t            ctrl [DEPTH];
    logic [ELEM_BITS-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]      match;
    logic                  hit;
    logic [IDX_BITS-1:0]   hit_index;

    assign accept    = start && !busy;
    assign op        = op_t'(operation);
    assign elem      = value[ELEM_BITS-1:0];
    assign append_ok = (count_reg != CNT_BITS'(DEPTH));
    assign remove_ok = ({1'b0, position} < count_reg);
    assign do_append = accept && (op == OP_APPEND) && append_ok;
    assign do_remove = accept && (op == OP_REMOVE) && remove_ok;
    assign do_find   = accept && (op == OP_FIND);

    // Per-cell control: the cell at the current end takes an appended value,
    // cells at and above the removed position take their neighbor's word.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            assign ctrl[i].load  = do_append && (count_reg == CNT_BITS'(i));
            assign ctrl[i].shift = do_remove && (IDX_BITS'(i) >= position);
            assign ctrl[i].probe = do_find;
            assign ctrl[i].live  = (CNT_BITS'(i) < count_reg);

            if (i == DEPTH - 1)
            begin : g_last
                clt_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[i]),
                    .value      (elem),
                    .right_data (cell_data[i]),
                    .data       (cell_data[i]),
                    .match      (match[i])
                );
            end
            else
            begin : g_mid
                clt_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl[i]),
                    .value      (elem),
                    .right_data (cell_data[i + 1]),
                    .data       (cell_data[i]),
                    .match      (match[i])
                );
            end
        end
    endgenerate

    clt_find_tree u_find_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .match     (match),
        .hit       (hit),
        .hit_index (hit_index)
    );

    // Sequencer: append, remove and the unused code report straight away, a find
    // walks through the compare and group stages before it reports.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_APPEND:
                        begin
                            done_next   = 1'b1;
                            found_next  = '0;
                            if (append_ok)
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = STAT_FULL;
                            end
                        end
                        OP_REMOVE:
                        begin
                            done_next   = 1'b1;
                            found_next  = '0;
                            if (remove_ok)
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg - 1'b1;
                            end
                            else
                            begin
                                status_next = STAT_RANGE;
                            end
                        end
                        OP_FIND:
                        begin
                            state_next = S_MATCH;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            found_next  = '0;
                            status_next = STAT_RANGE;
                        end
                    endcase
                end
            end
            S_MATCH:
            begin
                state_next = S_GROUP;
            end
            S_GROUP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (hit)
                begin
                    status_next = STAT_OK;
                    found_next  = hit_index;
                end
                else
                begin
                    status_next = STAT_NOTFOUND;
                    found_next  = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign count          = count_reg;

    // A find reports once it has passed the compare and group stages.
    a_find_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_FIND)) |-> ##2 done_next)
        else $error("find result not produced on time");

    // Every other command reports in the cycle right after its transfer.
    a_quick_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op != OP_FIND)) |=> done)
        else $error("single-cycle command result missing");

    // The entry count never exceeds the capacity.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above capacity");

    // A full report only comes from a list at capacity.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status_reg == STAT_FULL)) |-> (count_reg == CNT_BITS'(DEPTH)))
        else $error("full reported below capacity");

endmodule

>>> sv/clt_cell.sv
// One storage cell of the compacting list table chain.
// Depends on clt_pkg for the element width and the cell control struct.
`timescale 1ns / 1ps

module clt_cell
    import clt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [ELEM_BITS-1:0] value,
    input  logic [ELEM_BITS-1:0] right_data,
    output logic [ELEM_BITS-1:0] data,
    output logic                 match
);

    logic [ELEM_BITS-1:0] data_reg;
    logic [ELEM_BITS-1:0] data_next;
    logic                 match_reg;
    logic                 match_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = value;
        end
        else if (ctrl.shift)
        begin
            data_next = right_data;
        end
        match_next = match_reg;
        if (ctrl.probe)
        begin
            match_next = ctrl.live && (data_reg == value);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

>>> sv/clt_find_tree.sv
// Two-level first-match encoder over the match flags of the cell chain.
// Depends on clt_pkg for depth, group size and index widths.
`timescale 1ns / 1ps

module clt_find_tree
    import clt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DEPTH-1:0]    match,
    output logic                hit,
    output logic [IDX_BITS-1:0] hit_index
);

    logic [NUM_GROUPS-1:0] grp_any_reg;
    logic [NUM_GROUPS-1:0] grp_any_next;
    logic [GSEL_BITS-1:0]  grp_idx_reg  [NUM_GROUPS];
    logic [GSEL_BITS-1:0]  grp_idx_next [NUM_GROUPS];

    // First stage: lowest set flag inside each group of eight.
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = GROUP_SIZE - 1; b >= 0; b--)
            begin
                if (match[g * GROUP_SIZE + b])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GSEL_BITS'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_any_reg <= '0;
        end
        else
        begin
            grp_any_reg <= grp_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    // Second stage: lowest group that has a match.
    always_comb
    begin
        hit       = 1'b0;
        hit_index = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                hit       = 1'b1;
                hit_index = {GSEL_BITS'(g), grp_idx_reg[g]};
            end
        end
    end

endmodule

>>> sim/clt_checker.sv
// Checker for the compacting list table: follows command and result transfers,
// predicts every result and compares it field by field. Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_checker
    import clt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [31:0] value,
    input  logic [5:0]  position,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [5:0]  found_position,
    input  logic [6:0]  count,
    output int          errors,
    output int          pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        status_t               st;
        logic [IDX_BITS-1:0]   hit;
        logic [CNT_BITS-1:0]   len;
    } list_result_t;

    logic [ELEM_BITS-1:0] list_words [DEPTH];
    int                   list_len;
    list_result_t         expected_results [$];
    list_result_t         oldest;
    int                   fail_count;

    initial begin
        errors     = 0;
        pending    = 0;
        fail_count = 0;
        list_len   = 0;
    end

    // Applies one command to the shadow list and returns the result it gives.
    function automatic list_result_t apply_table_op(op_t op, logic [31:0] val,
                                                    logic [5:0] pos);
        list_result_t         r;
        logic [ELEM_BITS-1:0] key;
        r.st  = STAT_OK;
        r.hit = '0;
        key   = val[ELEM_BITS-1:0];
        case (op)
            OP_APPEND:
                if (list_len >= DEPTH) begin
                    r.st = STAT_FULL;
                end else begin
                    list_words[list_len] = key;
                    list_len++;
                end
            OP_REMOVE:
                if (int'(pos) >= list_len) begin
                    r.st = STAT_RANGE;
                end else begin
                    for (int i = int'(pos); i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            OP_FIND:
            begin
                r.st = STAT_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_words[i] == key) begin
                        r.st  = STAT_OK;
                        r.hit = i[IDX_BITS-1:0];
                        break;
                    end
                end
            end
            default:
                r.st = STAT_RANGE;
        endcase
        r.len = list_len[CNT_BITS-1:0];
        return r;
    endfunction

    // A result leaves the block in the cycle after its command at the earliest,
    // so the result seen at an edge is retired before that edge's command.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            list_len = 0;
            expected_results.delete();
            pending <= 0;
        end else begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result with nothing outstanding: status %0d pos %0d count %0d",
                                 $realtime, status, found_position, count);
                    end
                end else begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.st || found_position !== oldest.hit ||
                        count !== oldest.len) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch: expected status %0d pos %0d count %0d, got status %0d pos %0d count %0d",
                                     $realtime, oldest.st, oldest.hit, oldest.len,
                                     status, found_position, count);
                        end
                    end
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_table_op(op_t'(operation), value, position));
            end
            pending <= expected_results.size();
            errors  <= fail_count;
        end
    end

endmodule

>>> sim/tb_compacting_list_table.sv
// Top of the compacting list table testbench: clock, reset, command stimulus
// and the verdict. Depends on clt_pkg, compacting_list_table and clt_checker.
`timescale 1ns / 1ps

module tb_compacting_list_table;
    import clt_pkg::*;

    // Cycles without any transfer, command or result, before the run is
    // declared hung. Even a long sender gap or a find is far shorter.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last result so a stray extra strobe shows up.
    localparam int TAIL_CYCLES    = 8;
    localparam int RESET_CYCLES   = 7;
    localparam int PHASE_ITEMS    = 125;
    localparam int NUM_PHASES     = 4;
    localparam int POOL_SIZE      = 8;

    // Command mixes used by the random part. Growing fills the list to
    // capacity and keeps appending into a full list; shrinking drains it.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } mix_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  operation = OP_APPEND;
    logic [31:0] value = '0;
    logic [5:0]  position = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  found_position;
    logic [6:0]  count;

    int          errors;
    int          pending;
    int          idle_pct = 0;
    int          quiet_cycles = 0;
    int          last_count = 0;
    logic [31:0] value_pool [POOL_SIZE];

    // Sender idling per phase, in percent. The receiver cannot hold results
    // off, so the phases meant for receiver stalls only differ in their mix:
    // the third phase runs without gaps and the fourth keeps the 38 percent
    // sender gaps of the combined phase.
    int          phase_idle [NUM_PHASES] = '{0, 73, 0, 38};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    compacting_list_table u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .value          (value),
        .position       (position),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .count          (count)
    );

    clt_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .value          (value),
        .position       (position),
        .done           (done),
        .status         (status),
        .found_position (found_position),
        .count          (count),
        .errors         (errors),
        .pending        (pending)
    );

    // The count reported by the block steers remove positions toward live
    // entries. It may be stale, which only adds the odd out-of-range
    // remove.
    always @(posedge clk) begin
        if (done) begin
            last_count <= count;
        end
    end

    // Watchdog: any command or result transfer restarts the quiet count.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("compacting_list_table verification failed");
                $finish;
            end
        end
    end

    // Presents one command and returns right after the edge that transfers
    // it. Random gaps go in front of the command. In each time step start
    // gets a single assignment, so a start that stays high across
    // back-to-back commands is never dropped and raised in the same step.
    task automatic send_cmd(input op_t op, input logic [31:0] val, input logic [5:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        position  <= pos;
        @(posedge clk);
        while (busy) begin
            @(posedge clk);
        end
    endtask

    // Stops issuing commands until every outstanding result has come back.
    // The first edge lets the checker count the command just transferred.
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    // One random command. Values mostly come from a small pool so that finds
    // hit and duplicates are common; the rest are full-width random words.
    task automatic random_cmd(input mix_t mix);
        int          roll;
        int          append_cut;
        int          remove_cut;
        int          find_cut;
        int          top_pos;
        op_t         op;
        logic [31:0] val;
        logic [5:0]  pos;
        case (mix)
            MIX_GROW:
            begin
                append_cut = 80;
                remove_cut = 85;
                find_cut   = 98;
            end
            MIX_SHRINK:
            begin
                append_cut = 15;
                remove_cut = 75;
                find_cut   = 97;
            end
            default:
            begin
                append_cut = 40;
                remove_cut = 70;
                find_cut   = 97;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < append_cut) begin
            op = OP_APPEND;
        end else if (roll < remove_cut) begin
            op = OP_REMOVE;
        end else if (roll < find_cut) begin
            op = OP_FIND;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(99) < 65) begin
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            val = $urandom;
        end
        // Positions: mostly among the live entries, some at the last entry,
        // and some anywhere in the field, which covers out-of-range removes.
        top_pos = (last_count > 0) ? last_count - 1 : 0;
        roll = $urandom_range(99);
        if (roll < 15) begin
            pos = 6'($urandom_range(63));
        end else if (roll < 30) begin
            pos = 6'(top_pos);
        end else begin
            pos = 6'($urandom_range(top_pos));
        end
        send_cmd(op, val, pos);
    endtask

    initial begin
        int   item;
        mix_t mix;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, back to back. An empty list: find misses, removes
        // at the lowest and highest positions are out of range, and the
        // unused operation code is rejected.
        send_cmd(OP_FIND,   32'h0000_0000, 6'd0);
        send_cmd(OP_REMOVE, 32'h0000_0000, 6'd0);
        send_cmd(OP_REMOVE, 32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_UNUSED, 32'h0000_0000, 6'd0);
        // Extreme values with a duplicate, so a find must report the first
        // of two matching entries.
        send_cmd(OP_APPEND, 32'h0000_0000, 6'd0);
        send_cmd(OP_APPEND, 32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_APPEND, 32'hA5A5_A5A5, 6'd0);
        send_cmd(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_FIND,   32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_FIND,   32'h0000_0000, 6'd0);
        send_cmd(OP_FIND,   32'h1234_5678, 6'd0);
        // Remove exactly at the count, then from the head and from the tail,
        // and check that the later entries moved down.
        send_cmd(OP_REMOVE, 32'h0000_0000, 6'd4);
        send_cmd(OP_REMOVE, 32'h0000_0000, 6'd0);
        send_cmd(OP_FIND,   32'hFFFF_FFFF, 6'd0);
        send_cmd(OP_REMOVE, 32'hFFFF_FFFF, 6'd2);
        send_cmd(OP_FIND,   32'hA5A5_A5A5, 6'd0);
        send_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send_cmd(OP_APPEND, 32'h5A5A_5A5A, 6'd0);
        send_cmd(OP_APPEND, 32'h8000_0000, 6'd0);
        send_cmd(OP_APPEND, 32'h0000_0001, 6'd0);
        send_cmd(OP_REMOVE, 32'h0000_0000, 6'd63);
        send_cmd(OP_FIND,   32'h0000_0001, 6'd0);
        wait_all_results();

        // Random part. The first stretch fills the list to capacity and
        // keeps appending into it; after that the mix rotates so the list
        // drains, grows again and hovers. Each phase ends with a full pause
        // until every result is back.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_pct = phase_idle[phase];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                item = phase * PHASE_ITEMS + k;
                if (item < 120) begin
                    mix = MIX_GROW;
                end else begin
                    case ((item / 60) % 3)
                        0:       mix = MIX_SHRINK;
                        1:       mix = MIX_GROW;
                        default: mix = MIX_BALANCED;
                    endcase
                end
                random_cmd(mix);
            end
            wait_all_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("compacting_list_table verification clean");
        end else begin
            $display("compacting_list_table verification failed");
        end
        $finish;
    end

endmodule
